### rtl/sdlc_frame_checker_crc16_unit_macros.svh
// assertion macros used by the frame checker rtl
`ifndef SDLC_FRAME_CHECKER_CRC16_UNIT_MACROS_SVH
`define SDLC_FRAME_CHECKER_CRC16_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// next-cycle implication, disabled while in reset
`define SFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

### rtl/sfc_pkg.sv
// types, constants and crc function for the sdlc frame checker
`timescale 1ns / 1ps
`default_nettype none

package sfc_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 4096;
  localparam int HDR_BYTES = 3;
  localparam int FCS_BYTES = 2;
  localparam int MIN_FRAME = 5;
  localparam int LEN_W = 12;
  localparam logic [LEN_W-1:0] LEN_CAP = 12'hFFF;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOF  = 1'b1
  } item_kind_t;

  typedef enum logic [1:0] {
    VERDICT_OK        = 2'd0,
    VERDICT_TOO_SHORT = 2'd1,
    VERDICT_CRC_BAD   = 2'd2,
    VERDICT_TOO_LONG  = 2'd3
  } verdict_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } in_req_t;

  typedef struct packed {
    item_kind_t       item_kind;
    logic [7:0]       payload_byte;
    logic [7:0]       station_address;
    logic [7:0]       control_byte;
    logic [7:0]       type_byte;
    logic [LEN_W-1:0] payload_length;
    verdict_t         verdict;
    logic             run_last;
  } out_req_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/sdlc_frame_checker_crc16_unit.sv
// top level of the sdlc frame checker with crc-16/x-25 fcs check
// usage:
//   in_valid/in_ready/in_data carry one frame byte per request, end_of_frame
//   set on the last byte of a frame. out_valid/out_ready/out_data carry
//   results: data bytes (passed on two bytes late, once past the header) and
//   one verdict per frame with header fields, payload length and status.
//   a downstream user discards the streamed data when the verdict is not ok.
// path: a taken input request waits in the input register, then moves into
//   the four-entry output queue when that register advances.
// throughput: one input request per cycle unless stalled; the byte-wide crc
//   update, length counter and header capture fit the single stage between
//   the input register and the output queue. a final byte that also releases
//   a data byte adds two results, so the output side sets the pace then.
// reset: synchronous, active low; clears the crc to 0xffff, the byte count,
//   the overlong flag, the input valid bit and the queue pointers and count.
// stall: when out_ready stays low the queue fills; the input stage holds and
//   in_ready drops when it is full and fewer than two entries are free.
`timescale 1ns / 1ps
`default_nettype none

`include "sdlc_frame_checker_crc16_unit_macros.svh"

module sdlc_frame_checker_crc16_unit #(
  parameter int MAX_FRAME_BYTES = sfc_pkg::MAX_FRAME_BYTES_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire sfc_pkg::in_req_t in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output sfc_pkg::out_req_t out_data
);

  localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int EXT_W = (CNT_W > sfc_pkg::LEN_W) ? CNT_W : sfc_pkg::LEN_W;
  localparam int DEPTH = sfc_pkg::OUT_DEPTH;
  localparam int PTR_W = sfc_pkg::OUT_PTR_W;
  localparam int QCNT_W = PTR_W + 1;

  // input register
  logic             in_vld_r;
  sfc_pkg::in_req_t in_q_r;

  // frame state
  logic [15:0]      crc_r, crc_nxt;
  logic [CNT_W-1:0] bytes_seen_r, bytes_seen_nxt;
  logic             overlong_r, overlong_nxt;
  logic [7:0]       hold_r [2];
  logic [7:0]       hdr_r [3];

  // output queue
  sfc_pkg::out_req_t q_mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  logic              go;
  logic              pop;
  logic [CNT_W-1:0]  p;
  logic [7:0]        b;
  logic              eof;
  logic [15:0]       crc_upd;
  logic              has_data;
  logic [CNT_W-1:0]  len;
  logic [EXT_W-1:0]  diff;
  logic [15:0]       got;
  sfc_pkg::verdict_t vd;
  sfc_pkg::out_req_t data_res, eof_res;
  logic [1:0]        push_n;

  assign go  = in_vld_r && (cnt_r <= QCNT_W'(DEPTH - 2));
  assign pop = out_valid && out_ready;
  assign in_ready = !in_vld_r || go;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_mem[rd_ptr_r];

  assign p   = bytes_seen_r;
  assign b   = in_q_r.frame_byte;
  assign eof = in_q_r.end_of_frame;

  always_comb begin
    crc_upd  = (p >= CNT_W'(sfc_pkg::FCS_BYTES)) ? sfc_pkg::crc_byte(crc_r, hold_r[0]) : crc_r;
    has_data = (p >= CNT_W'(sfc_pkg::HDR_BYTES + sfc_pkg::FCS_BYTES));

    if (p >= CNT_W'(MAX_FRAME_BYTES)) begin
      len          = p;
      overlong_nxt = 1'b1;
    end else begin
      len          = p + CNT_W'(1);
      overlong_nxt = overlong_r;
    end

    diff = EXT_W'(len) - EXT_W'(sfc_pkg::MIN_FRAME);
    got  = {b, hold_r[1]};

    if (overlong_nxt) begin
      vd = sfc_pkg::VERDICT_TOO_LONG;
    end else if (~crc_upd != got) begin
      vd = sfc_pkg::VERDICT_CRC_BAD;
    end else begin
      vd = sfc_pkg::VERDICT_OK;
    end

    data_res              = '0;
    data_res.item_kind    = sfc_pkg::KIND_DATA;
    data_res.payload_byte = hold_r[0];
    data_res.verdict      = sfc_pkg::VERDICT_OK;
    data_res.run_last     = !eof;

    eof_res           = '0;
    eof_res.item_kind = sfc_pkg::KIND_EOF;
    eof_res.run_last  = 1'b1;
    if (len < CNT_W'(sfc_pkg::MIN_FRAME)) begin
      eof_res.verdict = sfc_pkg::VERDICT_TOO_SHORT;
    end else begin
      eof_res.station_address = hdr_r[0];
      eof_res.control_byte    = hdr_r[1];
      eof_res.type_byte       = hdr_r[2];
      eof_res.payload_length  = (diff > EXT_W'(sfc_pkg::LEN_CAP)) ? sfc_pkg::LEN_CAP
                                                                  : diff[sfc_pkg::LEN_W-1:0];
      eof_res.verdict         = vd;
    end

    if (eof) begin
      crc_nxt        = sfc_pkg::CRC_INIT;
      bytes_seen_nxt = '0;
    end else begin
      crc_nxt        = crc_upd;
      bytes_seen_nxt = len;
    end

    push_n  = go ? ({1'b0, has_data} + {1'b0, eof}) : 2'd0;
    cnt_nxt = cnt_r + QCNT_W'(push_n) - QCNT_W'(pop);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r     <= 1'b0;
      crc_r        <= sfc_pkg::CRC_INIT;
      bytes_seen_r <= '0;
      overlong_r   <= 1'b0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (go) begin
        crc_r        <= crc_nxt;
        bytes_seen_r <= bytes_seen_nxt;
        overlong_r   <= eof ? 1'b0 : overlong_nxt;
        wr_ptr_r     <= wr_ptr_r + PTR_W'(push_n);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q_r <= in_data;
    end
    if (go) begin
      hold_r[0] <= hold_r[1];
      hold_r[1] <= b;
      for (int i = 0; i < sfc_pkg::HDR_BYTES; i++) begin
        if (p == CNT_W'(i)) begin
          hdr_r[i] <= b;
        end
      end
      if (has_data) begin
        q_mem[wr_ptr_r] <= data_res;
        if (eof) begin
          q_mem[wr_ptr_r + PTR_W'(1)] <= eof_res;
        end
      end else if (eof) begin
        q_mem[wr_ptr_r] <= eof_res;
      end
    end
  end

  `SFC_ASSERT_IMPL(a_queue_bound, clk, rst_n, 1'b1, cnt_r <= QCNT_W'(DEPTH))
  `SFC_ASSERT_IMPL(a_overlong_sat, clk, rst_n, overlong_r, bytes_seen_r == CNT_W'(MAX_FRAME_BYTES))
  `SFC_ASSERT_NEXT(a_eof_clears, clk, rst_n, go && eof, bytes_seen_r == '0 && !overlong_r)
  `SFC_ASSERT_NEXT(a_pop_only, clk, rst_n, pop && !go, cnt_r == $past(cnt_r) - QCNT_W'(1))

endmodule

`default_nettype wire
